@@ src/lkss_pkg.sv @@
// Shared types, constants and command codes for the location keyed small set.
`default_nettype none

package lkss_pkg;

    // Storage sizing
    localparam int CAPACITY    = 81;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Operation codes carried in the cmd field
    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_ERASE_H  = 3'd1;
    localparam logic [2:0] CMD_ERASE_AT = 3'd2;
    localparam logic [2:0] CMD_CONTAINS = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;
    localparam logic [2:0] CMD_READ_AT  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] piece_handle;
        logic [3:0]  loc_x;
        logic [3:0]  loc_y;
        logic [6:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [6:0]  count;
        logic [15:0] out_handle;
        logic [3:0]  out_x;
        logic [3:0]  out_y;
    } t_out_item;

    // One stored entry
    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [3:0]             col;
        logic [3:0]             row;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_step;
        logic       shift_pos;
        logic       shift_hit;
        logic       shift_step;
        logic       read_start;
        logic       capture;
        logic       write_ins;
        logic       clear;
        logic       dec_count;
        logic       set_hit;
        logic       set_status;
        logic [1:0] status;
        logic       emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       pos_ok;
        logic       full;
        logic       match;
        logic       scan_done;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/location_keyed_small_set_unit.sv @@
// The entry memory's single read port sets the pace: one stored entry per cycle
// during a scan or a shift-down. One item is in work at a time; the next item is
// taken in the cycle after the result is loaded, and a stalled result holds the
// controller. Reset clears the count to zero and the output valid; entry memory is
// not cleared.
`default_nettype none

module location_keyed_small_set_unit
    import lkss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_stall,
    input  wire t_in_item  i_in_item,
    output      logic      o_out_valid,
    input  wire logic      i_out_stall,
    output      t_out_item o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lkss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    lkss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

`default_nettype wire

@@ src/lkss_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lkss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/lkss_ctrl.sv @@
// Controller state machine that sequences scan, shift, insert and read operations.
`default_nettype none

module lkss_ctrl
    import lkss_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output      logic     o_in_stall,
    input  wire t_dp_stat i_stat,
    output      t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_SHIFT,
        S_RDWAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a new item only when idle
    assign o_in_stall = (r_state != S_IDLE);

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.cmd) inside
                    CMD_INSERT, CMD_ERASE_H, CMD_CONTAINS: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    CMD_ERASE_AT: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.shift_pos = 1'b1;
                            n_state         = S_SHIFT;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                            n_state          = S_OUT;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_OUT;
                    end
                    CMD_READ_AT: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.read_start = 1'b1;
                            n_state          = S_RDWAIT;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                            n_state          = S_OUT;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    // Stop at the first matching entry
                    unique case (i_stat.cmd) inside
                        CMD_INSERT: begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_MISS;
                            n_state          = S_OUT;
                        end
                        CMD_ERASE_H: begin
                            o_cmd.set_hit   = 1'b1;
                            o_cmd.shift_hit = 1'b1;
                            n_state         = S_SHIFT;
                        end
                        default: begin
                            o_cmd.set_hit = 1'b1;
                            n_state       = S_OUT;
                        end
                    endcase
                end else if (i_stat.scan_done) begin
                    // Whole set seen without a match
                    unique case (i_stat.cmd) inside
                        CMD_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = ST_FULL;
                            end else begin
                                o_cmd.write_ins = 1'b1;
                            end
                        end
                        CMD_ERASE_H: begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_MISS;
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_RDWAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/lkss_dp.sv @@
// Datapath: entry memory, count, scan pointer, compare and result registers.
`default_nettype none

module lkss_dp
    import lkss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_item,
    output      logic      o_out_valid,
    input  wire logic      i_out_stall,
    output      t_out_item o_out_item,
    input  wire t_dp_cmd   i_cmd,
    output      t_dp_stat  o_stat
);

    // Latched item
    logic [2:0]             r_cmd;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [3:0]             r_x;
    logic [3:0]             r_y;
    logic [6:0]             r_pos;

    // Set state and scan pointer
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_pend;

    // Result under construction
    logic [1:0] r_res_status;
    logic       r_res_hit;
    t_entry     r_res_entry;

    // Memory port signals
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;
    logic [CNT_W-1:0] prev_idx;
    logic             key_eq;

    lkss_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Compare returned entry against the key of this item
    always_comb begin
        if (r_cmd == CMD_ERASE_H) begin
            key_eq = (rd_data.handle == r_handle);
        end else begin
            key_eq = (rd_data.col == r_x) && (rd_data.row == r_y);
        end
    end

    assign prev_idx = r_rd_idx - CNT_W'(1);

    // Drive memory ports
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr[IDX_W-1:0];
        we      = 1'b0;
        waddr   = r_count[IDX_W-1:0];
        wdata   = '{handle: r_handle, col: r_x, row: r_y};
        if (i_cmd.scan_step || i_cmd.shift_step) begin
            rd_en = (r_addr < r_count);
        end
        if (i_cmd.read_start) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(r_pos);
        end
        if (i_cmd.write_ins) begin
            we = 1'b1;
        end
        if (i_cmd.shift_step && r_pend) begin
            // Move the entry just read down by one place
            we    = 1'b1;
            waddr = prev_idx[IDX_W-1:0];
            wdata = rd_data;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.pos_ok    = (32'(r_pos) < 32'(r_count));
        o_stat.full      = (32'(r_count) >= 32'(CAPACITY));
        o_stat.match     = r_pend && key_eq;
        o_stat.scan_done = !r_pend && (r_addr >= r_count);
        o_stat.out_free  = !o_out_valid || !i_out_stall;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.write_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Scan pointer and issued index
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= CNT_W'(rd_addr);
        end
        if (i_cmd.scan_start) begin
            r_addr <= '0;
        end else if (i_cmd.shift_pos) begin
            r_addr <= CNT_W'(r_pos) + CNT_W'(1);
        end else if (i_cmd.shift_hit) begin
            r_addr <= r_rd_idx + CNT_W'(1);
        end else if (rd_en && !i_cmd.read_start) begin
            r_addr <= r_addr + CNT_W'(1);
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd        <= i_in_item.cmd;
            r_handle     <= HANDLE_BITS'(i_in_item.piece_handle);
            r_x          <= i_in_item.loc_x;
            r_y          <= i_in_item.loc_y;
            r_pos        <= i_in_item.position;
            r_res_status <= ST_OK;
            r_res_hit    <= 1'b0;
            r_res_entry  <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
            if (i_cmd.set_hit) begin
                r_res_hit <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_res_entry <= rd_data;
            end
        end
        if (i_cmd.emit) begin
            o_out_item.status     <= r_res_status;
            o_out_item.hit        <= r_res_hit;
            o_out_item.count      <= 7'(r_count);
            o_out_item.out_handle <= 16'(r_res_entry.handle);
            o_out_item.out_x      <= r_res_entry.col;
            o_out_item.out_y      <= r_res_entry.row;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the location keyed small set unit.
`timescale 1ns / 1ps

module tb
    import lkss_pkg::*;
();

    // Unused command codes: the block must answer them as a no-op
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1425;
    localparam int PHASE_LEN    = 150;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 700;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        t_in_item  op;
        bit        typed;
        t_out_item want;
    } t_directed_op;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Shadow copy of the set, kept in step with accepted items
    logic [HANDLE_BITS-1:0] set_handle [CAPACITY];
    logic [3:0]             set_col    [CAPACITY];
    logic [3:0]             set_row    [CAPACITY];
    int                     set_count = 0;

    t_out_item    pending_results [$];
    t_directed_op directed_ops [$];
    int           cycle_no = 0;
    int           items_taken = 0;
    int           fails = 0;
    bit           hold_off = 1'b0;
    int           stall_left = 0;

    location_keyed_small_set_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic bit holds_location(logic [3:0] x, logic [3:0] y);
        for (int i = 0; i < set_count; i++)
            if (set_col[i] == x && set_row[i] == y)
                return 1'b1;
        return 1'b0;
    endfunction

    // Remove one entry and close the gap
    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < set_count; i++) begin
            set_handle[i] = set_handle[i + 1];
            set_col[i]    = set_col[i + 1];
            set_row[i]    = set_row[i + 1];
        end
        set_count--;
    endfunction

    // Apply one item to the shadow set and return the result it yields
    function automatic t_out_item apply_set_op(t_in_item it);
        t_out_item r;
        int        idx;
        logic [HANDLE_BITS-1:0] key;
        r   = '0;
        idx = -1;
        key = it.piece_handle[HANDLE_BITS-1:0];
        case (it.cmd)
            CMD_INSERT: begin
                if (holds_location(it.loc_x, it.loc_y)) begin
                    r.status = ST_MISS;
                end else if (set_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    set_handle[set_count] = key;
                    set_col[set_count]    = it.loc_x;
                    set_row[set_count]    = it.loc_y;
                    set_count++;
                end
            end
            CMD_ERASE_H: begin
                for (int i = 0; i < set_count && idx < 0; i++)
                    if (set_handle[i] == key)
                        idx = i;
                if (idx >= 0) begin
                    drop_entry(idx);
                    r.hit = 1'b1;
                end else begin
                    r.status = ST_MISS;
                end
            end
            CMD_ERASE_AT: begin
                if (int'(it.position) < set_count)
                    drop_entry(int'(it.position));
                else
                    r.status = ST_RANGE;
            end
            CMD_CONTAINS: r.hit = holds_location(it.loc_x, it.loc_y);
            CMD_CLEAR: set_count = 0;
            CMD_READ_AT: begin
                if (int'(it.position) < set_count) begin
                    r.out_handle = 16'(set_handle[it.position]);
                    r.out_x      = set_col[it.position];
                    r.out_y      = set_row[it.position];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.count = 7'(set_count);
        return r;
    endfunction

    // Idle length: mostly none or short, a few long, none in calm stretches
    function automatic int idle_len();
        int r;
        if (((cycle_no / 3000) % 5) == 4)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_out_item res(logic [1:0] st, logic hit, logic [6:0] cnt,
                                      logic [15:0] oh, logic [3:0] ox, logic [3:0] oy);
        t_out_item r;
        r.status     = st;
        r.hit        = hit;
        r.count      = cnt;
        r.out_handle = oh;
        r.out_x      = ox;
        r.out_y      = oy;
        return r;
    endfunction

    function automatic void add_op(logic [2:0] c, logic [15:0] h, logic [3:0] x,
                                   logic [3:0] y, logic [6:0] p, bit typed = 1'b0,
                                   t_out_item want = '0);
        t_directed_op d;
        d.op.cmd          = c;
        d.op.piece_handle = h;
        d.op.loc_x        = x;
        d.op.loc_y        = y;
        d.op.position     = p;
        d.typed           = typed;
        d.want            = want;
        directed_ops.push_back(d);
    endfunction

    // Random item: fill, mixed and drain stretches over the live contents
    function automatic t_in_item random_op(int k);
        t_in_item it;
        int       r;
        int       pick;
        int       stage;
        it.cmd          = 3'($urandom_range(0, 7));
        it.piece_handle = 16'($urandom);
        it.loc_x        = 4'($urandom);
        it.loc_y        = 4'($urandom);
        it.position     = 7'($urandom);
        stage = (k / PHASE_LEN) % 3;
        r     = $urandom_range(0, 99);
        if (r < 2) begin
            it.cmd = (r == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end else if (stage == 0) begin
            if (r < 75)      it.cmd = CMD_INSERT;
            else if (r < 85) it.cmd = CMD_CONTAINS;
            else if (r < 93) it.cmd = CMD_READ_AT;
            else if (r < 97) it.cmd = CMD_ERASE_H;
            else             it.cmd = CMD_ERASE_AT;
        end else if (stage == 1) begin
            if (r < 32)      it.cmd = CMD_INSERT;
            else if (r < 46) it.cmd = CMD_ERASE_H;
            else if (r < 58) it.cmd = CMD_ERASE_AT;
            else if (r < 74) it.cmd = CMD_CONTAINS;
            else if (r < 98) it.cmd = CMD_READ_AT;
            else             it.cmd = CMD_CLEAR;
        end else begin
            if (r < 15)      it.cmd = CMD_INSERT;
            else if (r < 45) it.cmd = CMD_ERASE_H;
            else if (r < 75) it.cmd = CMD_ERASE_AT;
            else if (r < 85) it.cmd = CMD_CONTAINS;
            else if (r < 98) it.cmd = CMD_READ_AT;
            else             it.cmd = CMD_CLEAR;
        end
        pick = (set_count > 0) ? $urandom_range(0, set_count - 1) : 0;
        case (it.cmd)
            CMD_INSERT: begin
                if (set_count > 0 && $urandom_range(0, 3) == 0) begin
                    it.loc_x = set_col[pick];
                    it.loc_y = set_row[pick];
                end
                if ($urandom_range(0, 3) == 0)
                    it.piece_handle = 16'($urandom_range(0, 7));
            end
            CMD_ERASE_H: begin
                if (set_count > 0 && $urandom_range(0, 9) < 6)
                    it.piece_handle = 16'(set_handle[pick]);
            end
            CMD_CONTAINS: begin
                if (set_count > 0 && $urandom_range(0, 1) == 0) begin
                    it.loc_x = set_col[pick];
                    it.loc_y = set_row[pick];
                end
            end
            CMD_ERASE_AT, CMD_READ_AT: begin
                if (set_count > 0 && $urandom_range(0, 9) < 8)
                    it.position = 7'(pick);
            end
            default: ;
        endcase
        return it;
    endfunction

    // Offer one item, wait for it to be taken, then log its expected result
    task automatic offer(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_taken++;
        @(negedge i_clk);
        predicted = apply_set_op(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Receiver stalls, plus one long hold-off once traffic is under way
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_stall <= hold_off || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = idle_len();
        end
    end

    initial begin
        do @(negedge i_clk); while (items_taken < HOLD_AFTER);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Compare each delivered item with the oldest expected result
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: st=%0d hit=%0d cnt=%0d h=%h x=%0d y=%0d",
                             o_out_item.status, o_out_item.hit, o_out_item.count,
                             o_out_item.out_handle, o_out_item.out_x, o_out_item.out_y);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status || o_out_item.hit !== want.hit ||
                    o_out_item.count !== want.count ||
                    o_out_item.out_handle !== want.out_handle ||
                    o_out_item.out_x !== want.out_x || o_out_item.out_y !== want.out_y) begin
                    fails++;
                    if (fails <= 10) begin
                        $write("mismatch: want st=%0d hit=%0d cnt=%0d h=%h x=%0d y=%0d",
                               want.status, want.hit, want.count, want.out_handle,
                               want.out_x, want.out_y);
                        $display(" / got st=%0d hit=%0d cnt=%0d h=%h x=%0d y=%0d",
                                 o_out_item.status, o_out_item.hit, o_out_item.count,
                                 o_out_item.out_handle, o_out_item.out_x,
                                 o_out_item.out_y);
                    end
                end
            end
        end
    end

    initial begin
        // Empty set: every lookup misses or is out of range
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd0,   1, res(ST_RANGE, 0, 0, 0, 0, 0));
        add_op(CMD_ERASE_AT, 16'h0000, 4'd0,  4'd0,  7'd127, 1, res(ST_RANGE, 0, 0, 0, 0, 0));
        add_op(CMD_ERASE_H,  16'hFFFF, 4'd15, 4'd15, 7'd0,   1, res(ST_MISS, 0, 0, 0, 0, 0));
        add_op(CMD_CONTAINS, 16'h0000, 4'd0,  4'd0,  7'd0,   1, res(ST_OK, 0, 0, 0, 0, 0));
        add_op(CMD_CLEAR,    16'h0000, 4'd0,  4'd0,  7'd0,   1, res(ST_OK, 0, 0, 0, 0, 0));
        // Extremes, duplicate location, duplicate handle
        add_op(CMD_INSERT,   16'hFFFF, 4'd15, 4'd15, 7'd0,   1, res(ST_OK, 0, 1, 0, 0, 0));
        add_op(CMD_INSERT,   16'h0000, 4'd15, 4'd15, 7'd127, 1, res(ST_MISS, 0, 1, 0, 0, 0));
        add_op(CMD_CONTAINS, 16'h1234, 4'd15, 4'd15, 7'd0,   1, res(ST_OK, 1, 1, 0, 0, 0));
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd0,   1,
               res(ST_OK, 0, 1, 16'hFFFF, 4'd15, 4'd15));
        add_op(CMD_INSERT,   16'h0000, 4'd0,  4'd0,  7'd0,   1, res(ST_OK, 0, 2, 0, 0, 0));
        add_op(CMD_INSERT,   16'hFFFF, 4'd8,  4'd8,  7'd0,   1, res(ST_OK, 0, 3, 0, 0, 0));
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd2,   1,
               res(ST_OK, 0, 3, 16'hFFFF, 4'd8, 4'd8));
        // Erase of a repeated handle takes the lowest position
        add_op(CMD_ERASE_H,  16'hFFFF, 4'd0,  4'd0,  7'd0);
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd0);
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd1);
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd2,   1, res(ST_RANGE, 0, 2, 0, 0, 0));
        add_op(CMD_SPARE_6,  16'hFFFF, 4'd15, 4'd15, 7'd127, 1, res(ST_OK, 0, 2, 0, 0, 0));
        add_op(CMD_SPARE_7,  16'h0000, 4'd0,  4'd0,  7'd0,   1, res(ST_OK, 0, 2, 0, 0, 0));
        add_op(CMD_ERASE_AT, 16'h0000, 4'd0,  4'd0,  7'd0);
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd0);
        add_op(CMD_INSERT,   16'h5A5A, 4'd0,  4'd15, 7'd0);
        add_op(CMD_ERASE_AT, 16'h0000, 4'd0,  4'd0,  7'd1);
        add_op(CMD_CONTAINS, 16'h0000, 4'd0,  4'd15, 7'd0);
        add_op(CMD_CLEAR,    16'hFFFF, 4'd15, 4'd15, 7'd127, 1, res(ST_OK, 0, 0, 0, 0, 0));
        add_op(CMD_READ_AT,  16'h0000, 4'd0,  4'd0,  7'd127, 1, res(ST_RANGE, 0, 0, 0, 0, 0));

        // Hold reset, release on a falling edge
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_ops[i])
            offer(directed_ops[i].op, directed_ops[i].typed, directed_ops[i].want);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // Pause the sender once until the set has answered everything
            if (k == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending_results.size() != 0);
            end
            offer(random_op(k), 1'b0, '0);
        end

        // Drain outstanding results, then allow time for any stray output
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
